// ----- rtl/bbe_pkg.sv -----
`timescale 1ns / 1ps
package bbe_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int WIDTH_BITS    = 11;
  localparam int HEIGHT_BITS   = 13;
  localparam int CFG_BITS      = 13;
  localparam int HEIGHT_LIMIT  = 4096;
  localparam int WIDTH_RESET   = 640;
  localparam int HEIGHT_RESET  = 480;
  localparam int PIX_BITS      = 24;
  localparam int SUM_BITS      = 12;
  localparam int NUM_BITS      = 13;
  localparam int RECIP_SHIFT   = 16;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic       load_px;
    logic       rd_en;
    logic       wr_en;
    logic       shift;
    logic       par;
    logic       sum_en;
    logic       mul_en;
    logic       out_load;
    logic [2:0] row_en;
    logic [2:0] col_en;
    logic       last;
    logic       eoi;
  } cmd_t;

  // floor(2^16 / (2*cnt)); the datapath fixes the low-by-one error
  function automatic logic [15:0] recip(input logic [3:0] cnt);
    logic [15:0] m;
    unique case (cnt)
      4'd1:    m = 16'd32768;
      4'd2:    m = 16'd16384;
      4'd3:    m = 16'd10922;
      4'd4:    m = 16'd8192;
      4'd5:    m = 16'd6553;
      4'd6:    m = 16'd5461;
      4'd7:    m = 16'd4681;
      4'd8:    m = 16'd4096;
      4'd9:    m = 16'd3640;
      default: m = 16'd0;
    endcase
    return m;
  endfunction

endpackage

// ----- rtl/bbe_ctrl.sv -----
`timescale 1ns / 1ps
module bbe_ctrl #(
  parameter int MAX_WIDTH = bbe_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_mode_i,
  output logic                          in_ready_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_addr_i,
  input  logic [bbe_pkg::CFG_BITS-1:0]  cfg_wdata_i,
  input  logic                          out_free_i,
  output bbe_pkg::cmd_t                 cmd_o,
  output logic [$clog2(MAX_WIDTH)-1:0]  addr_o
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = AW + 1;
  localparam int HB = bbe_pkg::HEIGHT_BITS;
  localparam int WB = bbe_pkg::WIDTH_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_PIX_RD, S_PIX_SH, S_FL_A0, S_FL_A1, S_FL_A2, S_FL_SH,
    S_SUM, S_MUL, S_OUT
  } state_e;

  state_e          state_q;
  logic [WB-1:0]   width_q;
  logic [HB-1:0]   height_q;
  logic [HB-1:0]   row_q;
  logic [AW-1:0]   col_q;
  logic [CW-1:0]   flush_q;
  logic [AW-1:0]   cur_c_q;
  logic            par_q;
  logic [2:0]      rmask_q;
  logic [2:0]      cmask_a_q;
  logic [2:0]      cmask_b_q;
  logic            need_a_q;
  logic            need_b_q;
  logic            last_a_q;
  logic            eoi_a_q;
  logic            cur_b_q;

  logic [CW-1:0]   eff_w;
  logic [HB-1:0]   eff_h;
  logic [CW-1:0]   col_next;
  logic [CW-1:0]   k_next;
  logic            accept;
  logic            pix_ok;
  logic            fl_ok;
  logic            r_ge1;

  always_comb begin
    if (width_q == '0) begin
      eff_w = CW'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = CW'(width_q);
    end
    if (height_q == '0) begin
      eff_h = HB'(1);
    end else if (32'(height_q) > 32'(bbe_pkg::HEIGHT_LIMIT)) begin
      eff_h = HB'(bbe_pkg::HEIGHT_LIMIT);
    end else begin
      eff_h = height_q;
    end
  end

  // a register write takes the idle cycle, so no transfer is taken with it
  assign in_ready_o = (state_q == S_IDLE) && !cfg_we_i;
  assign accept     = in_valid_i && in_ready_o;
  assign col_next   = CW'(col_q) + CW'(1);
  assign k_next     = flush_q + CW'(1);
  assign pix_ok     = (row_q < eff_h) && (CW'(col_q) < eff_w);
  assign fl_ok      = (row_q >= eff_h) && (flush_q < eff_w);
  assign r_ge1      = (row_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      width_q   <= WB'(bbe_pkg::WIDTH_RESET);
      height_q  <= HB'(bbe_pkg::HEIGHT_RESET);
      row_q     <= '0;
      col_q     <= '0;
      flush_q   <= '0;
      cur_c_q   <= '0;
      par_q     <= 1'b0;
      rmask_q   <= '0;
      cmask_a_q <= '0;
      cmask_b_q <= '0;
      need_a_q  <= 1'b0;
      need_b_q  <= 1'b0;
      last_a_q  <= 1'b0;
      eoi_a_q   <= 1'b0;
      cur_b_q   <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (cfg_we_i) begin
            if (cfg_addr_i == bbe_pkg::REG_WIDTH) begin
              width_q <= cfg_wdata_i[WB-1:0];
            end else begin
              height_q <= cfg_wdata_i;
            end
            row_q   <= '0;
            col_q   <= '0;
            flush_q <= '0;
          end else if (accept) begin
            par_q <= row_q[0];
            if (in_mode_i == bbe_pkg::MODE_PIXEL && pix_ok) begin
              cur_c_q   <= col_q;
              rmask_q   <= {1'b1, 1'b1, row_q >= HB'(2)};
              cmask_a_q <= {1'b1, 1'b1, col_q >= AW'(2)};
              cmask_b_q <= {1'b1, col_q != '0, 1'b0};
              need_a_q  <= r_ge1 && (col_q != '0);
              need_b_q  <= r_ge1 && (col_next == eff_w);
              last_a_q  <= !(r_ge1 && (col_next == eff_w));
              eoi_a_q   <= 1'b0;
              if (col_next >= eff_w) begin
                col_q <= '0;
                row_q <= row_q + HB'(1);
              end else begin
                col_q <= col_q + AW'(1);
              end
              state_q <= S_PIX_RD;
            end else if (in_mode_i == bbe_pkg::MODE_FLUSH && fl_ok) begin
              cur_c_q   <= flush_q[AW-1:0];
              rmask_q   <= {1'b0, 1'b1, eff_h >= HB'(2)};
              cmask_a_q <= {k_next < eff_w, 1'b1, flush_q != '0};
              cmask_b_q <= '0;
              need_a_q  <= 1'b1;
              need_b_q  <= 1'b0;
              last_a_q  <= 1'b1;
              eoi_a_q   <= (k_next == eff_w);
              if (k_next >= eff_w) begin
                row_q   <= '0;
                col_q   <= '0;
                flush_q <= '0;
              end else begin
                flush_q <= k_next;
              end
              state_q <= S_FL_A0;
            end
          end
        end
        S_PIX_RD: state_q <= S_PIX_SH;
        S_PIX_SH: begin
          if (need_a_q) begin
            cur_b_q <= 1'b0;
            state_q <= S_SUM;
          end else if (need_b_q) begin
            cur_b_q <= 1'b1;
            state_q <= S_SUM;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_FL_A0: state_q <= S_FL_A1;
        S_FL_A1: state_q <= S_FL_A2;
        S_FL_A2: state_q <= S_FL_SH;
        S_FL_SH: begin
          cur_b_q <= 1'b0;
          state_q <= S_SUM;
        end
        S_SUM: state_q <= S_MUL;
        S_MUL: state_q <= S_OUT;
        S_OUT: begin
          if (out_free_i) begin
            if (!cur_b_q && need_b_q) begin
              cur_b_q <= 1'b1;
              state_q <= S_SUM;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.load_px  = accept;
    cmd_o.par      = par_q;
    cmd_o.row_en   = rmask_q;
    cmd_o.col_en   = cur_b_q ? cmask_b_q : cmask_a_q;
    cmd_o.last     = cur_b_q ? 1'b1 : last_a_q;
    cmd_o.eoi      = cur_b_q ? 1'b0 : eoi_a_q;
    addr_o         = cur_c_q;
    unique case (state_q)
      S_PIX_RD: cmd_o.rd_en = 1'b1;
      S_PIX_SH: begin
        cmd_o.shift = 1'b1;
        cmd_o.wr_en = 1'b1;
      end
      S_FL_A0: begin
        cmd_o.rd_en = 1'b1;
        addr_o      = cur_c_q - AW'(1);
      end
      S_FL_A1: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.shift = 1'b1;
      end
      S_FL_A2: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.shift = 1'b1;
        addr_o      = cur_c_q + AW'(1);
      end
      S_FL_SH:  cmd_o.shift    = 1'b1;
      S_SUM:    cmd_o.sum_en   = 1'b1;
      S_MUL:    cmd_o.mul_en   = 1'b1;
      S_OUT:    cmd_o.out_load = out_free_i;
      default:  cmd_o.rd_en    = 1'b0;
    endcase
  end

endmodule

// ----- rtl/bbe_dp.sv -----
`timescale 1ns / 1ps
module bbe_dp #(
  parameter int MAX_WIDTH = bbe_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bbe_pkg::cmd_t                 cmd_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]  addr_i,
  input  logic [bbe_pkg::PIX_BITS-1:0]  px_i,
  output logic                          out_free_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bbe_pkg::PIX_BITS-1:0]  out_px_o,
  output logic                          out_last_o,
  output logic                          out_eoi_o
);

  localparam int PB = bbe_pkg::PIX_BITS;
  localparam int SB = bbe_pkg::SUM_BITS;
  localparam int NB = bbe_pkg::NUM_BITS;
  localparam int RS = bbe_pkg::RECIP_SHIFT;

  logic [PB-1:0] bank0_mem [MAX_WIDTH];
  logic [PB-1:0] bank1_mem [MAX_WIDTH];
  logic [PB-1:0] rd0_q;
  logic [PB-1:0] rd1_q;
  logic [PB-1:0] px_q;
  logic [PB-1:0] win_q [3][3];

  logic [SB-1:0] sum_d [3];
  logic [SB-1:0] sum_q [3];
  logic [3:0]    cnt_d;
  logic [3:0]    cnt_q;
  logic [NB-1:0] num_d [3];
  logic [NB-1:0] num_q [3];
  logic [7:0]    quo_d [3];
  logic [7:0]    quo_q [3];
  logic [7:0]    fix_d [3];
  logic [4:0]    div;
  logic [15:0]   rcp;

  logic          out_valid_q;
  logic [PB-1:0] out_px_q;
  logic          out_last_q;
  logic          out_eoi_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && !cmd_i.par) begin
      bank0_mem[addr_i] <= px_q;
    end
    if (cmd_i.wr_en && cmd_i.par) begin
      bank1_mem[addr_i] <= px_q;
    end
    if (cmd_i.rd_en) begin
      rd0_q <= bank0_mem[addr_i];
      rd1_q <= bank1_mem[addr_i];
    end
  end

  // window rows: older row, previous row, current row; column 2 is the newest
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_px) begin
      px_q <= px_i;
    end
    if (cmd_i.shift) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= win_q[i][2];
      end
      win_q[0][2] <= cmd_i.par ? rd1_q : rd0_q;
      win_q[1][2] <= cmd_i.par ? rd0_q : rd1_q;
      win_q[2][2] <= px_q;
    end
  end

  always_comb begin
    cnt_d = '0;
    for (int ch = 0; ch < 3; ch++) begin
      sum_d[ch] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (cmd_i.row_en[i] && cmd_i.col_en[j]) begin
          cnt_d = cnt_d + 4'd1;
          for (int ch = 0; ch < 3; ch++) begin
            sum_d[ch] = sum_d[ch] + SB'(win_q[i][j][8*ch +: 8]);
          end
        end
      end
    end
  end

  // rounded mean (2*sum + cnt) / (2*cnt): reciprocal estimate, then one fix-up
  assign rcp = bbe_pkg::recip(cnt_q);
  assign div = {cnt_q, 1'b0};

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      logic [NB+15:0] prod;
      logic [NB-1:0]  rem;
      num_d[ch] = NB'({sum_q[ch], 1'b0}) + NB'(cnt_q);
      prod      = num_d[ch] * rcp;
      quo_d[ch] = prod[RS+7:RS];
      rem       = num_q[ch] - NB'(quo_q[ch]) * NB'(div);
      fix_d[ch] = (rem >= NB'(div)) ? quo_q[ch] + 8'd1 : quo_q[ch];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_en) begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
    if (cmd_i.mul_en) begin
      num_q <= num_d;
      quo_q <= quo_d;
    end
    if (cmd_i.out_load) begin
      out_px_q   <= {fix_d[2], fix_d[1], fix_d[0]};
      out_last_q <= cmd_i.last;
      out_eoi_q  <= cmd_i.eoi;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_free_o  = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_px_o    = out_px_q;
  assign out_last_o  = out_last_q;
  assign out_eoi_o   = out_eoi_q;

endmodule

// ----- rtl/box_blur_3x3_edge_aware_unit.sv -----
`timescale 1ns / 1ps
// 3x3 box blur of an rgb stream in raster order, mean over the in-image
// neighbors rounded half up. Results trail the input by one row and one
// pixel; after the last pixel, one flush item per column emits the bottom
// row. Items are taken one at a time. A pixel item reads the line buffers,
// shifts the window and makes 0, 1 or 2 results; a flush item reads three
// columns, shifts and makes one. Each result is a sum, reciprocal multiply
// and fix-up step in the shared datapath; a result waiting at the output
// stalls only while the next result must load. Two line-buffer banks of
// MAX_WIDTH pixels hold the previous rows. A register write restarts the
// frame and is taken only while idle; no input is taken during a write.
module box_blur_3x3_edge_aware_unit #(
  parameter int MAX_WIDTH = bbe_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [23:0]                   s_axis_tdata,  // red_in, green_in, blue_in
  input  logic                          s_axis_tuser,  // mode
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [23:0]                   m_axis_tdata,  // red_out, green_out, blue_out
  output logic                          m_axis_tlast,
  output logic                          m_axis_tuser,  // end_of_image
  input  logic                          cfg_we_i,
  input  logic                          cfg_addr_i,
  input  logic [bbe_pkg::CFG_BITS-1:0]  cfg_wdata_i
);

  localparam int AW = $clog2(MAX_WIDTH);

  bbe_pkg::cmd_t cmd;
  logic [AW-1:0] addr;
  logic          out_free;

  bbe_ctrl #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_mode_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .out_free_i (out_free),
    .cmd_o      (cmd),
    .addr_o     (addr)
  );

  bbe_dp #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .addr_i     (addr),
    .px_i       (s_axis_tdata),
    .out_free_o (out_free),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_px_o   (m_axis_tdata),
    .out_last_o (m_axis_tlast),
    .out_eoi_o  (m_axis_tuser)
  );

endmodule

// ----- verif/box_blur_3x3_edge_aware_unit_test.sv -----
`timescale 1ns / 1ps
module box_blur_3x3_edge_aware_unit_test;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RAND_ITEMS  = 750;
  localparam int SETTLE      = 20;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
    logic       eoi;
  } blur_px_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       typed;
    blur_px_t   want;
  } pix_item_t;

  typedef enum logic [1:0] {ROW_SET_W, ROW_SET_H, ROW_ITEM} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [12:0] value;
    pix_item_t   item;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;
  logic        cfg_we_i = 1'b0;
  logic        cfg_addr_i = bbe_pkg::REG_WIDTH;
  logic [bbe_pkg::CFG_BITS-1:0] cfg_wdata_i = '0;

  box_blur_3x3_edge_aware_unit u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser,
    .cfg_we_i, .cfg_addr_i, .cfg_wdata_i
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // blur predictor state
  logic [23:0] line_mem [2][1024];
  logic [23:0] win [3][3];
  int unsigned row_pos, col_pos, flush_pos;
  int unsigned width_reg, height_reg;

  pix_item_t stim_q[$];
  blur_px_t  blur_q[$];
  blur_px_t  step_out[$];
  pix_item_t cur_item = '0;
  int        errors = 0;
  int        results_seen = 0;
  int        items_taken = 0;
  int        images_run = 0;
  int        cycles = 0;
  int        burst_left = 0, gap_left = 0;
  int        hold_left = 0, stall_pct = 0;
  bit        hold_go = 1'b0;

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > 1024) return 1024;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg == 0) return 1;
    if (height_reg > bbe_pkg::HEIGHT_LIMIT) return bbe_pkg::HEIGHT_LIMIT;
    return height_reg;
  endfunction

  function automatic void restart_frame();
    row_pos = 0;
    col_pos = 0;
    flush_pos = 0;
  endfunction

  // mean rounded half up
  function automatic blur_px_t mean_px(int unsigned sr, int unsigned sg, int unsigned sb,
                                       int unsigned cnt, logic eoi);
    blur_px_t p;
    p.red   = cnt == 0 ? 8'd0 : 8'((2 * sr + cnt) / (2 * cnt));
    p.green = cnt == 0 ? 8'd0 : 8'((2 * sg + cnt) / (2 * cnt));
    p.blue  = cnt == 0 ? 8'd0 : 8'((2 * sb + cnt) / (2 * cnt));
    p.last  = 1'b0;
    p.eoi   = eoi;
    return p;
  endfunction

  // window column j holds image column c-2+j, result centered on column cc
  function automatic blur_px_t window_mean(int cc, int r, int c, int w);
    int unsigned sr, sg, sb, cnt;
    int col;
    sr = 0; sg = 0; sb = 0; cnt = 0;
    for (int i = 0; i < 3; i++) begin
      if (r - 2 + i < 0) continue;
      for (int j = cc - 1; j <= cc + 1; j++) begin
        col = c - 2 + j;
        if (j < 0 || j > 2 || col < 0 || col >= w) continue;
        sr += win[i][j][23:16];
        sg += win[i][j][15:8];
        sb += win[i][j][7:0];
        cnt++;
      end
    end
    return mean_px(sr, sg, sb, cnt, 1'b0);
  endfunction

  function automatic void blur_step(pix_item_t it, ref blur_px_t res[$]);
    int unsigned w, h, r, c, k, y0, sr, sg, sb, cnt;
    int col;
    blur_px_t p;
    w = eff_width();
    h = eff_height();
    res.delete();
    if (it.mode == bbe_pkg::MODE_PIXEL) begin
      if (row_pos >= h || col_pos >= w) return;
      r = row_pos;
      c = col_pos;
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = line_mem[r & 1][c];
      win[1][2] = line_mem[(r + 1) & 1][c];
      win[2][2] = {it.red, it.green, it.blue};
      line_mem[r & 1][c] = {it.red, it.green, it.blue};
      if (r >= 1) begin
        if (c >= 1) res.push_back(window_mean(1, r, c, w));
        if (c == w - 1) res.push_back(window_mean(2, r, c, w));
      end
      col_pos = c + 1;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos = r + 1;
      end
      if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    end else begin
      k = flush_pos;
      if (row_pos < h || k >= w) return;
      sr = 0; sg = 0; sb = 0; cnt = 0;
      y0 = h >= 2 ? h - 2 : h - 1;
      for (int unsigned y = y0; y <= h - 1; y++) begin
        for (int dx = -1; dx <= 1; dx++) begin
          col = int'(k) + dx;
          if (col < 0 || col >= int'(w)) continue;
          sr += line_mem[y & 1][col][23:16];
          sg += line_mem[y & 1][col][15:8];
          sb += line_mem[y & 1][col][7:0];
          cnt++;
        end
      end
      p = mean_px(sr, sg, sb, cnt, k == w - 1);
      p.last = 1'b1;
      res.push_back(p);
      flush_pos = k + 1;
      if (flush_pos >= w) restart_frame();
    end
  endfunction

  initial begin
    foreach (line_mem[i, j]) line_mem[i][j] = '0;
    foreach (win[i, j]) win[i][j] = '0;
    restart_frame();
    width_reg = bbe_pkg::WIDTH_RESET;
    height_reg = bbe_pkg::HEIGHT_RESET;
  end

  // sender: bursts with random gaps
  always @(posedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || s_axis_tready)) begin
      if (gap_left > 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (stim_q.size() > 0) begin
        pix_item_t it;
        it = stim_q.pop_front();
        cur_item <= it;
        s_axis_tdata <= {it.blue, it.green, it.red};
        s_axis_tuser <= it.mode;
        s_axis_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stall rate, redrawn over time, plus one long hold-off
  always @(posedge clk_i) begin
    if (cycles % 256 == 0) stall_pct <= ($urandom_range(0, 3) < 2) ? 0 : $urandom_range(20, 70);
    if (hold_go) begin
      hold_go = 1'b0;
      hold_left <= 400;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // transfer monitor and checker
  always @(posedge clk_i) begin
    blur_px_t got, want;
    cycles <= cycles + 1;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      blur_step(cur_item, step_out);
      items_taken <= items_taken + 1;
      if (cur_item.typed) blur_q.push_back(cur_item.want);
      else foreach (step_out[i]) blur_q.push_back(step_out[i]);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16],
              m_axis_tlast, m_axis_tuser};
      results_seen <= results_seen + 1;
      if (blur_q.size() == 0) begin
        errors <= errors + 1;
        if (errors < 10) $display("unexpected result %h", got);
      end else begin
        want = blur_q.pop_front();
        if (got !== want) begin
          errors <= errors + 1;
          if (errors < 10)
            $display("mismatch: rgb/last/eoi expected %h %h %h %b %b got %h %h %h %b %b",
                     want.red, want.green, want.blue, want.last, want.eoi,
                     got.red, got.green, got.blue, got.last, got.eoi);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(negedge clk_i);
    while (stim_q.size() > 0 || s_axis_tvalid || blur_q.size() > 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(logic addr, logic [12:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= addr;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (addr == bbe_pkg::REG_WIDTH) width_reg = value & 13'h7ff;
    else height_reg = value;
    restart_frame();
  endtask

  function automatic pix_item_t pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    pix_item_t it;
    it = '0;
    it.mode = bbe_pkg::MODE_PIXEL;
    it.red = r;
    it.green = g;
    it.blue = b;
    return it;
  endfunction

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pix_item_t rand_pixel();
    return pixel(rand_chan(), rand_chan(), rand_chan());
  endfunction

  function automatic pix_item_t flush_item();
    pix_item_t it;
    it = rand_pixel();
    it.mode = bbe_pkg::MODE_FLUSH;
    return it;
  endfunction

  // whole image with content from rand_pixel, optionally noisy, and if noisy sometimes cut short
  task automatic queue_image(int w, int h, bit noisy);
    int cut;
    cut = (noisy && $urandom_range(0, 19) == 0) ? $urandom_range(0, w * h) : -1;
    for (int n = 0; n < w * h; n++) begin
      if (n == cut) return;
      if (noisy && $urandom_range(0, 24) == 0) stim_q.push_back(flush_item());
      stim_q.push_back(rand_pixel());
    end
    for (int k = 0; k < w; k++) begin
      if (noisy && $urandom_range(0, 24) == 0) stim_q.push_back(rand_pixel());
      stim_q.push_back(flush_item());
    end
    images_run++;
  endtask

  dir_row_t dir_tab [25];
  int rand_count;
  int w, h;

  initial begin
    // single pixel images, rounding on a 2x1 image, a 2x2 image whose last pixel gives two results
    dir_tab = '{
      '{ROW_SET_W, 13'd1, '0},
      '{ROW_SET_H, 13'd1, '0},
      '{ROW_ITEM, 13'd0, '{bbe_pkg::MODE_FLUSH, 8'd0, 8'd0, 8'd0, 1'b0, '0}},
      '{ROW_ITEM, 13'd0, '{bbe_pkg::MODE_PIXEL, 8'd255, 8'd0, 8'd128, 1'b0, '0}},
      '{ROW_ITEM, 13'd0, '{bbe_pkg::MODE_PIXEL, 8'd1, 8'd2, 8'd3, 1'b0, '0}},
      '{ROW_ITEM, 13'd0, '{bbe_pkg::MODE_FLUSH, 8'd0, 8'd0, 8'd0, 1'b1,
                          '{8'd255, 8'd0, 8'd128, 1'b1, 1'b1}}},
      '{ROW_ITEM, 13'd0, '{bbe_pkg::MODE_FLUSH, 8'd9, 8'd9, 8'd9, 1'b0, '0}},
      '{ROW_SET_W, 13'd0, '0},
      '{ROW_SET_H, 13'd0, '0},
      '{ROW_ITEM, 13'd0, '{bbe_pkg::MODE_PIXEL, 8'd0, 8'd255, 8'd1, 1'b0, '0}},
      '{ROW_ITEM, 13'd0, '{bbe_pkg::MODE_FLUSH, 8'd0, 8'd0, 8'd0, 1'b1,
                          '{8'd0, 8'd255, 8'd1, 1'b1, 1'b1}}},
      '{ROW_SET_W, 13'd2, '0},
      '{ROW_SET_H, 13'd1, '0},
      '{ROW_ITEM, 13'd0, '{bbe_pkg::MODE_PIXEL, 8'd10, 8'd20, 8'd30, 1'b0, '0}},
      '{ROW_ITEM, 13'd0, '{bbe_pkg::MODE_PIXEL, 8'd11, 8'd21, 8'd31, 1'b0, '0}},
      '{ROW_ITEM, 13'd0, '{bbe_pkg::MODE_FLUSH, 8'd0, 8'd0, 8'd0, 1'b1,
                          '{8'd11, 8'd21, 8'd31, 1'b1, 1'b0}}},
      '{ROW_ITEM, 13'd0, '{bbe_pkg::MODE_FLUSH, 8'd0, 8'd0, 8'd0, 1'b1,
                          '{8'd11, 8'd21, 8'd31, 1'b1, 1'b1}}},
      '{ROW_SET_W, 13'd2, '0},
      '{ROW_SET_H, 13'd2, '0},
      '{ROW_ITEM, 13'd0, '{bbe_pkg::MODE_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0, '0}},
      '{ROW_ITEM, 13'd0, '{bbe_pkg::MODE_PIXEL, 8'd0, 8'd0, 8'd0, 1'b0, '0}},
      '{ROW_ITEM, 13'd0, '{bbe_pkg::MODE_PIXEL, 8'd255, 8'd0, 8'd255, 1'b0, '0}},
      '{ROW_ITEM, 13'd0, '{bbe_pkg::MODE_PIXEL, 8'd0, 8'd255, 8'd0, 1'b0, '0}},
      '{ROW_ITEM, 13'd0, '{bbe_pkg::MODE_FLUSH, 8'd0, 8'd0, 8'd0, 1'b0, '0}},
      '{ROW_ITEM, 13'd0, '{bbe_pkg::MODE_FLUSH, 8'd0, 8'd0, 8'd0, 1'b0, '0}}
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_ITEM) begin
        stim_q.push_back(dir_tab[i].item);
      end else begin
        wait_idle();
        write_reg(dir_tab[i].kind == ROW_SET_W ? bbe_pkg::REG_WIDTH : bbe_pkg::REG_HEIGHT,
                  dir_tab[i].value);
      end
    end

    rand_count = 0;
    while (rand_count < RAND_ITEMS) begin
      wait_idle();
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      write_reg(bbe_pkg::REG_WIDTH, 13'(w));
      write_reg(bbe_pkg::REG_HEIGHT, 13'(h));
      if (rand_count == 0) hold_go = 1'b1;
      repeat ($urandom_range(1, 3)) queue_image(w, h, 1'b1);
      rand_count += stim_q.size();
      // occasional stray item on an idle frame boundary
      if ($urandom_range(0, 3) == 0) stim_q.push_back($urandom_range(0, 1) ? flush_item()
                                                                             : rand_pixel());
    end

    // width beyond the limit: one clamped row, then the first bottom-row results
    wait_idle();
    write_reg(bbe_pkg::REG_WIDTH, 13'd2047);
    write_reg(bbe_pkg::REG_HEIGHT, 13'd1);
    for (int n = 0; n < 1024; n++) stim_q.push_back(rand_pixel());
    stim_q.push_back(flush_item());
    stim_q.push_back(flush_item());
    wait_idle();

    errors += blur_q.size();
    $display("covered %0d images, %0d input transfers, %0d results compared",
             images_run, items_taken, results_seen);
    $display("sizes from 1x1 up to a clamped width of 1024, with noise and cut frames");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
